// ----- sv/lsa_pkg.sv -----
// Shared types, constants and color tables for the LED string animation block.
package lsa_pkg;

    // One pixel color, red in the top byte.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // Sequencer states of the tick engine.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAB,
        ST_MARQ,
        ST_EMIT
    } t_state;

    // Phases of a color fade.
    localparam logic [1:0] FADE_LOAD = 2'd0;
    localparam logic [1:0] FADE_RG   = 2'd1;
    localparam logic [1:0] FADE_GB   = 2'd2;
    localparam logic [1:0] FADE_BR   = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_MARQUEE = 1'b0;
    localparam logic REG_CABINET = 1'b1;

    // Marquee modes and the cabinet fade mode.
    localparam logic       MARQ_FADE    = 1'b0;
    localparam logic [2:0] CAB_FADE     = 3'd7;

    // Color levels and table sizes.
    localparam logic [7:0] LVL_FULL     = 8'd255;
    localparam logic [7:0] LVL_DIM      = 8'd80;
    localparam logic [7:0] LVL_OFF      = 8'd0;
    localparam logic [2:0] RB_LAST      = 3'd6;
    localparam logic [2:0] TICKS_FRAME0 = 3'd0;

    // Seven-entry rainbow table.
    function automatic t_rgb rb_color(input logic [2:0] k);
        t_rgb c;
        case (k)
            3'd0:    c = '{LVL_FULL, LVL_OFF,  LVL_OFF};
            3'd1:    c = '{LVL_FULL, LVL_DIM,  LVL_OFF};
            3'd2:    c = '{LVL_FULL, LVL_FULL, LVL_OFF};
            3'd3:    c = '{LVL_OFF,  LVL_FULL, LVL_OFF};
            3'd4:    c = '{LVL_OFF,  LVL_DIM,  LVL_FULL};
            3'd5:    c = '{LVL_OFF,  LVL_OFF,  LVL_FULL};
            3'd6:    c = '{LVL_DIM,  LVL_OFF,  LVL_FULL};
            default: c = '{LVL_OFF,  LVL_OFF,  LVL_OFF};
        endcase
        return c;
    endfunction

    // Fixed cabinet colors by mode; the fade mode has no fixed color.
    function automatic t_rgb cab_fixed(input logic [2:0] mode);
        t_rgb c;
        case (mode)
            3'd1:    c = '{LVL_FULL, LVL_OFF,  LVL_OFF};
            3'd2:    c = '{LVL_FULL, LVL_FULL, LVL_OFF};
            3'd3:    c = '{LVL_OFF,  LVL_FULL, LVL_OFF};
            3'd4:    c = '{LVL_OFF,  LVL_FULL, LVL_FULL};
            3'd5:    c = '{LVL_OFF,  LVL_OFF,  LVL_FULL};
            3'd6:    c = '{LVL_FULL, LVL_OFF,  LVL_FULL};
            default: c = '{LVL_OFF,  LVL_OFF,  LVL_OFF};
        endcase
        return c;
    endfunction

endpackage

// ----- sv/led_string_animation.sv -----
// Top level of the LED string animation block: tick sequencer and pixel emitter.
//
// Each accepted tick item runs through a small sequencer: ST_IDLE takes the
// item, in ST_CAB the shared fade unit steps the cabinet fade, and in ST_MARQ
// it steps the marquee fade (or the rainbow frame counter advances). If
// anything visible changed, the block then emits the string as
// min(STRING_COUNT, 32) pixel items, one per cycle while i_ready is high, the
// final one flagged by o_last. o_ready is low while a tick is in progress. The
// first MARQUEE_COUNT pixels form the marquee and the rest the cabinet.
// Registers: marquee_mode at byte address 0, cabinet_mode at byte address 4;
// write them only while idle.
module led_string_animation #(
    parameter int MARQUEE_COUNT = 16,
    parameter int STRING_COUNT  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_restart,
    // Pixel output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_led_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_last,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lsa_pkg::*;

    localparam int EMIT_COUNT = (STRING_COUNT > 32) ? 32 : STRING_COUNT;
    localparam logic [4:0] PIX_LAST = 5'(EMIT_COUNT - 1);
    localparam logic [5:0] MARQ_END = 6'(MARQUEE_COUNT);

    t_state     r_state, n_state;
    logic       r_marq_mode, n_marq_mode;
    logic [2:0] r_cab_mode, n_cab_mode;
    logic [1:0] r_fade_phase, n_fade_phase;
    t_rgb       r_fade_color, n_fade_color;
    logic [1:0] r_cab_phase, n_cab_phase;
    t_rgb       r_cab_color, n_cab_color;
    logic [2:0] r_rb_next, n_rb_next;
    logic [2:0] r_rb_shown, n_rb_shown;
    logic [2:0] r_tick, n_tick;
    logic       r_pending, n_pending;
    logic       r_draw, n_draw;
    logic [4:0] r_pix, n_pix;
    logic [2:0] r_rb_k, n_rb_k;

    logic       w_cfg_wr;
    logic       w_accept;
    logic       w_draw_now;
    logic [1:0] w_fu_phase_in, w_fu_phase_out;
    t_rgb       w_fu_color_in, w_fu_color_out;
    logic [7:0] w_fu_start_g;
    t_rgb       w_pix_color;

    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_accept = i_valid && o_ready;
    // A frame is drawn on a marquee fade, a new rainbow frame, or a redraw set in r_draw.
    assign w_draw_now = r_draw || (r_marq_mode == MARQ_FADE) || (r_tick == TICKS_FRAME0);

    // Shared fade unit: cabinet fade in ST_CAB, marquee fade otherwise.
    always_comb begin
        if (r_state == ST_CAB) begin
            w_fu_phase_in = r_cab_phase;
            w_fu_color_in = r_cab_color;
            w_fu_start_g  = LVL_FULL;
        end else begin
            w_fu_phase_in = r_fade_phase;
            w_fu_color_in = r_fade_color;
            w_fu_start_g  = LVL_OFF;
        end
    end

    lsa_fade u_fade (
        .i_phase   (w_fu_phase_in),
        .i_color   (w_fu_color_in),
        .i_start_g (w_fu_start_g),
        .o_phase   (w_fu_phase_out),
        .o_color   (w_fu_color_out)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CAB;
                end
            end
            ST_CAB: begin
                n_state = ST_MARQ;
            end
            ST_MARQ: begin
                n_state = w_draw_now ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_ready && (r_pix == PIX_LAST)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs of the sequencer.
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_EMIT: o_valid = 1'b1;
            default: begin
                o_ready = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    // Animation state updates and register writes.
    always_comb begin
        n_marq_mode  = r_marq_mode;
        n_cab_mode   = r_cab_mode;
        n_fade_phase = r_fade_phase;
        n_fade_color = r_fade_color;
        n_cab_phase  = r_cab_phase;
        n_cab_color  = r_cab_color;
        n_rb_next    = r_rb_next;
        n_rb_shown   = r_rb_shown;
        n_tick       = r_tick;
        n_pending    = r_pending;
        n_draw       = r_draw;
        n_pix        = r_pix;
        n_rb_k       = r_rb_k;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_draw = r_pending || i_restart;
                    if (i_restart) begin
                        n_fade_phase = FADE_LOAD;
                        n_cab_phase  = FADE_LOAD;
                        n_rb_next    = 3'd0;
                        n_tick       = TICKS_FRAME0;
                    end
                end
            end
            ST_CAB: begin
                if (r_cab_mode == CAB_FADE) begin
                    n_cab_phase = w_fu_phase_out;
                    n_cab_color = w_fu_color_out;
                    n_draw      = 1'b1;
                end
            end
            ST_MARQ: begin
                n_pix  = 5'd0;
                n_rb_k = r_rb_shown;
                if (r_marq_mode == MARQ_FADE) begin
                    n_fade_phase = w_fu_phase_out;
                    n_fade_color = w_fu_color_out;
                end else begin
                    if (r_tick == TICKS_FRAME0) begin
                        n_rb_shown = r_rb_next;
                        n_rb_k     = r_rb_next;
                        n_rb_next  = (r_rb_next == RB_LAST) ? 3'd0 : r_rb_next + 3'd1;
                    end
                    n_tick = r_tick + 3'd1;
                end
                if (w_draw_now) begin
                    n_pending = 1'b0;
                end
            end
            ST_EMIT: begin
                if (i_ready) begin
                    n_pix  = r_pix + 5'd1;
                    n_rb_k = (r_rb_k == RB_LAST) ? 3'd0 : r_rb_k + 3'd1;
                end
            end
            default: begin
                n_draw = r_draw;
            end
        endcase

        // Register writes are to arrive only while idle; the block does not enforce this.
        if (w_cfg_wr) begin
            n_pending = 1'b1;
            if (paddr[2] == REG_MARQUEE) begin
                n_marq_mode = pwdata[0];
                if (pwdata[0] != r_marq_mode) begin
                    n_fade_phase = FADE_LOAD;
                    n_rb_next    = 3'd0;
                    n_tick       = TICKS_FRAME0;
                end
            end else begin
                n_cab_mode = pwdata[2:0];
                if (pwdata[2:0] != r_cab_mode) begin
                    n_cab_phase = FADE_LOAD;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_marq_mode  <= 1'b0;
            r_cab_mode   <= 3'd0;
            r_fade_phase <= FADE_LOAD;
            r_fade_color <= '0;
            r_cab_phase  <= FADE_LOAD;
            r_cab_color  <= '0;
            r_rb_next    <= 3'd0;
            r_rb_shown   <= 3'd0;
            r_tick       <= TICKS_FRAME0;
            r_pending    <= 1'b0;
            r_draw       <= 1'b0;
            r_pix        <= 5'd0;
            r_rb_k       <= 3'd0;
        end else begin
            r_state      <= n_state;
            r_marq_mode  <= n_marq_mode;
            r_cab_mode   <= n_cab_mode;
            r_fade_phase <= n_fade_phase;
            r_fade_color <= n_fade_color;
            r_cab_phase  <= n_cab_phase;
            r_cab_color  <= n_cab_color;
            r_rb_next    <= n_rb_next;
            r_rb_shown   <= n_rb_shown;
            r_tick       <= n_tick;
            r_pending    <= n_pending;
            r_draw       <= n_draw;
            r_pix        <= n_pix;
            r_rb_k       <= n_rb_k;
        end
    end

    // Color of the pixel under the emit counter.
    always_comb begin
        if ({1'b0, r_pix} < MARQ_END) begin
            w_pix_color = (r_marq_mode == MARQ_FADE) ? r_fade_color : rb_color(r_rb_k);
        end else if (r_cab_mode == CAB_FADE) begin
            w_pix_color = r_cab_color;
        end else begin
            w_pix_color = cab_fixed(r_cab_mode);
        end
    end

    assign o_led_index = r_pix;
    assign o_red       = w_pix_color.r;
    assign o_green     = w_pix_color.g;
    assign o_blue      = w_pix_color.b;
    assign o_last      = (r_pix == PIX_LAST);

    // Register readback.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CABINET) ? {29'd0, r_cab_mode} : {31'd0, r_marq_mode};

`ifndef SYNTHESIS
    // An accepted tick keeps the input closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("input ready right after an accepted tick");

    // Within a run, each delivered pixel is followed by the next position.
    a_pixel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last) |=>
            (o_valid && (o_led_index == $past(o_led_index) + 5'd1)))
        else $error("pixel run broken or out of order");

    // Rainbow indexes stay inside the seven-entry table.
    a_rb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rb_next <= RB_LAST) && (r_rb_shown <= RB_LAST) && (r_rb_k <= RB_LAST))
        else $error("rainbow index beyond the table");

    // A run never starts while a redraw is still pending.
    a_pending_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARQ && w_draw_now) |=> (o_valid && !r_pending && r_pix == 5'd0))
        else $error("run started without clearing the pending redraw");
`endif

endmodule

// ----- sv/lsa_fade.sv -----
// Shared fade step unit: advances one color fade by one count.
module lsa_fade (
    input  logic [1:0]   i_phase,
    input  lsa_pkg::t_rgb i_color,
    input  logic [7:0]   i_start_g,
    output logic [1:0]   o_phase,
    output lsa_pkg::t_rgb o_color
);
    import lsa_pkg::*;

    // A fresh fade loads its start color and takes its first red-to-green step.
    always_comb begin
        logic [1:0] p;
        t_rgb       c;
        p = i_phase;
        c = i_color;
        if (p == FADE_LOAD) begin
            c = '{LVL_FULL, i_start_g, LVL_OFF};
            p = FADE_RG;
        end
        case (p)
            FADE_RG: begin
                c.r = c.r - 8'd1;
                c.g = c.g + 8'd1;
                if (c.r == LVL_OFF) begin
                    c.g = LVL_FULL;
                    p   = FADE_GB;
                end
            end
            FADE_GB: begin
                c.g = c.g - 8'd1;
                c.b = c.b + 8'd1;
                if (c.g == LVL_OFF) begin
                    c.b = LVL_FULL;
                    p   = FADE_BR;
                end
            end
            default: begin
                c.b = c.b - 8'd1;
                c.r = c.r + 8'd1;
                if (c.b == LVL_OFF) begin
                    p = FADE_LOAD;
                end
            end
        endcase
        o_phase = p;
        o_color = c;
    end

endmodule
